FILE: rtl/mt19937_generator_top_assert.svh
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Shared concurrent assertion forms, clocked on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef MT19937_GENERATOR_TOP_ASSERT_SVH
`define MT19937_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define MTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 generator package
// Sizes, constants, sequencer states and beat types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;

  localparam int WORD_W    = 32;
  localparam int BOUND_W   = 31;
  localparam int SHIFT_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = $clog2(STATE_WORDS);
  localparam int POS_W     = $clog2(STATE_WORDS + 1);

  localparam logic [IDX_W-1:0] MID_START = IDX_W'(MIDDLE_OFFSET % STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
  localparam logic [POS_W-1:0] POS_FULL  = POS_W'(STATE_WORDS);

  localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] HI_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LO_MASK   = 32'h7FFF_FFFF;
  localparam int                MIX_SHIFT = 30;
  localparam logic [WORD_W:0]   FULL_WORD = 33'h0_FFFF_FFFF;

  localparam logic [WORD_W-1:0]  RST_SEED     = 32'd5489;
  localparam logic [WORD_W-1:0]  RST_XOR_MASK = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0]  RST_MASK_B   = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0]  RST_MASK_C   = 32'hEFC6_0000;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_U  = 5'd11;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_S  = 5'd7;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_T  = 5'd15;
  localparam logic [SHIFT_W-1:0] RST_SHIFT_L  = 5'd18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED,
    REG_XOR_MASK,
    REG_MASK_B,
    REG_MASK_C,
    REG_SHIFT_U,
    REG_SHIFT_S,
    REG_SHIFT_T,
    REG_SHIFT_L
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_DRAW,
    KIND_RESEED
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED0,
    S_SEED_MUL,
    S_SEED_ADD,
    S_TW_PRE,
    S_TW_LD,
    S_TW_RD,
    S_TW_WR,
    S_RD,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_MUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0]  seed_value;
    logic [WORD_W-1:0]  twist_xor_mask;
    logic [WORD_W-1:0]  temper_mask_b;
    logic [WORD_W-1:0]  temper_mask_c;
    logic [SHIFT_W-1:0] shift_u;
    logic [SHIFT_W-1:0] shift_s;
    logic [SHIFT_W-1:0] shift_t;
    logic [SHIFT_W-1:0] shift_l;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [BOUND_W-1:0] max_value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  raw_word;
    logic [BOUND_W-1:0] scaled_value;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/mtg_mul.sv
// ----------------------------------------------------------------------------
// MT19937 shared multiplier
// 32x32 unsigned multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_mul (
  input  wire logic                         clk,
  input  wire logic [mtg_pkg::WORD_W-1:0]   op_a,
  input  wire logic [mtg_pkg::WORD_W-1:0]   op_b,
  output logic      [2*mtg_pkg::WORD_W-1:0] prod_r
);
  import mtg_pkg::*;

  logic [2*WORD_W-1:0] prod_nxt;

  assign prod_nxt = {{WORD_W{1'b0}}, op_a} * {{WORD_W{1'b0}}, op_b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/mtg_regs.sv
// ----------------------------------------------------------------------------
// MT19937 configuration registers
// Write-only register file for seed, twist mask and tempering parameters.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mtg_pkg::WORD_W-1:0]     cfg_data,
  output mtg_pkg::cfg_t                       cfg_r
);
  import mtg_pkg::*;

  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SEED:     cfg_nxt.seed_value     = cfg_data;
        REG_XOR_MASK: cfg_nxt.twist_xor_mask = cfg_data;
        REG_MASK_B:   cfg_nxt.temper_mask_b  = cfg_data;
        REG_MASK_C:   cfg_nxt.temper_mask_c  = cfg_data;
        REG_SHIFT_U:  cfg_nxt.shift_u        = cfg_data[SHIFT_W-1:0];
        REG_SHIFT_S:  cfg_nxt.shift_s        = cfg_data[SHIFT_W-1:0];
        REG_SHIFT_T:  cfg_nxt.shift_t        = cfg_data[SHIFT_W-1:0];
        REG_SHIFT_L:  cfg_nxt.shift_l        = cfg_data[SHIFT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed_value     <= RST_SEED;
      cfg_r.twist_xor_mask <= RST_XOR_MASK;
      cfg_r.temper_mask_b  <= RST_MASK_B;
      cfg_r.temper_mask_c  <= RST_MASK_C;
      cfg_r.shift_u        <= RST_SHIFT_U;
      cfg_r.shift_s        <= RST_SHIFT_S;
      cfg_r.shift_t        <= RST_SHIFT_T;
      cfg_r.shift_l        <= RST_SHIFT_L;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mtg_core.sv
// ----------------------------------------------------------------------------
// MT19937 sequencer core
// State table memory, seeding, twist, tempering and scaling; seeding and scaling share one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtg_pkg::cfg_t     cfg,
  input  wire logic              start,
  input  wire mtg_pkg::in_item_t in_item,
  output logic                   busy,
  output logic                   out_strobe,
  output mtg_pkg::out_item_t     out_item
);
  import mtg_pkg::*;

  `include "mt19937_generator_top_assert.svh"

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   a_idx_r, a_idx_nxt;
  logic [IDX_W-1:0]   m_idx_r, m_idx_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               seeded_r, seeded_nxt;
  logic [WORD_W-1:0]  prev_r, prev_nxt;
  logic [WORD_W-1:0]  cur_r, cur_nxt;
  logic [WORD_W-1:0]  temp_r, temp_nxt;
  kind_t              kind_r, kind_nxt;
  logic [BOUND_W-1:0] bound_r, bound_nxt;
  out_item_t          out_r, out_nxt;
  logic               strobe_r, strobe_nxt;

  logic [WORD_W-1:0]   mem [STATE_WORDS];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [WORD_W-1:0]   mem_wd;
  logic [IDX_W-1:0]    rd_a, rd_b;
  logic [WORD_W-1:0]   rda_r, rdb_r;

  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [2*WORD_W-1:0] prod;

  logic [WORD_W-1:0]   seed_word;
  logic [WORD_W-1:0]   twist_y;
  logic [WORD_W-1:0]   twist_v;
  logic [WORD_W:0]     scale_sum;
  logic [WORD_W-1:0]   scale_q;

  mtg_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rda_r <= mem[rd_a];
    rdb_r <= mem[rd_b];
  end

  assign seed_word = prod[WORD_W-1:0] + WORD_W'(idx_r);
  assign twist_y   = (cur_r & HI_MASK) | (rda_r & LO_MASK);
  assign twist_v   = rdb_r ^ (twist_y >> 1) ^ (twist_y[0] ? cfg.twist_xor_mask : '0);
  // P / (2^32-1) = hi + ((hi + lo) >= 2^32-1), since hi + lo < 2 * (2^32-1)
  assign scale_sum = {1'b0, prod[2*WORD_W-1:WORD_W]} + {1'b0, prod[WORD_W-1:0]};
  assign scale_q   = prod[2*WORD_W-1:WORD_W] + WORD_W'(scale_sum >= FULL_WORD);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    a_idx_nxt  = a_idx_r;
    m_idx_nxt  = m_idx_r;
    pos_nxt    = pos_r;
    seeded_nxt = seeded_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    temp_nxt   = temp_r;
    kind_nxt   = kind_r;
    bound_nxt  = bound_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    rd_a       = '0;
    rd_b       = '0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_item.kind;
          bound_nxt = in_item.max_value;
          if (in_item.kind == KIND_RESEED) begin
            state_nxt = S_SEED0;
          end else if (in_item.max_value == '0) begin
            out_nxt    = '0;
            strobe_nxt = 1'b1;
          end else if (!seeded_r) begin
            state_nxt = S_SEED0;
          end else if (pos_r >= POS_FULL) begin
            state_nxt = S_TW_PRE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_SEED0: begin
        mem_we    = 1'b1;
        mem_wa    = '0;
        mem_wd    = cfg.seed_value;
        prev_nxt  = cfg.seed_value;
        idx_nxt   = IDX_W'(1);
        state_nxt = S_SEED_MUL;
      end
      S_SEED_MUL: begin
        mul_a     = SEED_MULT;
        mul_b     = prev_r ^ (prev_r >> MIX_SHIFT);
        state_nxt = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        mem_we   = 1'b1;
        mem_wa   = idx_r;
        mem_wd   = seed_word;
        prev_nxt = seed_word;
        if (idx_r == LAST_IDX) begin
          pos_nxt    = POS_FULL;
          seeded_nxt = 1'b1;
          state_nxt  = (kind_r == KIND_DRAW) ? S_TW_PRE : S_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SEED_MUL;
        end
      end
      S_TW_PRE: begin
        rd_a      = '0;
        idx_nxt   = '0;
        a_idx_nxt = IDX_W'(1);
        m_idx_nxt = MID_START;
        state_nxt = S_TW_LD;
      end
      S_TW_LD: begin
        cur_nxt   = rda_r;
        state_nxt = S_TW_RD;
      end
      S_TW_RD: begin
        rd_a      = a_idx_r;
        rd_b      = m_idx_r;
        state_nxt = S_TW_WR;
      end
      S_TW_WR: begin
        mem_we  = 1'b1;
        mem_wa  = idx_r;
        mem_wd  = twist_v;
        cur_nxt = rda_r;
        if (idx_r == LAST_IDX) begin
          pos_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          a_idx_nxt = (a_idx_r == LAST_IDX) ? '0 : a_idx_r + IDX_W'(1);
          m_idx_nxt = (m_idx_r == LAST_IDX) ? '0 : m_idx_r + IDX_W'(1);
          state_nxt = S_TW_RD;
        end
      end
      S_RD: begin
        rd_a      = pos_r[IDX_W-1:0];
        pos_nxt   = pos_r + POS_W'(1);
        state_nxt = S_T1;
      end
      S_T1: begin
        temp_nxt  = rda_r ^ (rda_r >> cfg.shift_u);
        state_nxt = S_T2;
      end
      S_T2: begin
        temp_nxt  = temp_r ^ ((temp_r << cfg.shift_s) & cfg.temper_mask_b);
        state_nxt = S_T3;
      end
      S_T3: begin
        temp_nxt  = temp_r ^ ((temp_r << cfg.shift_t) & cfg.temper_mask_c);
        state_nxt = S_T4;
      end
      S_T4: begin
        temp_nxt  = temp_r ^ (temp_r >> cfg.shift_l);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        mul_a     = temp_r;
        mul_b     = {1'b0, bound_r};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_nxt.raw_word     = temp_r;
        out_nxt.scaled_value = scale_q[BOUND_W-1:0];
        strobe_nxt           = 1'b1;
        state_nxt            = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      a_idx_r  <= '0;
      m_idx_r  <= '0;
      pos_r    <= POS_FULL;
      seeded_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      a_idx_r  <= a_idx_nxt;
      m_idx_r  <= m_idx_nxt;
      pos_r    <= pos_nxt;
      seeded_r <= seeded_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    temp_r  <= temp_nxt;
    kind_r  <= kind_nxt;
    bound_r <= bound_nxt;
    out_r   <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  `MTG_ASSERT_NEXT(a_out_after_scale, state_r == S_OUT,
    strobe_r && state_r == S_IDLE, "scaled result not strobed")
  `MTG_ASSERT_NOW(a_read_in_range, state_r == S_RD,
    pos_r < POS_FULL && seeded_r, "word read past end of table")
  `MTG_ASSERT_NEXT(a_zero_bound, start && !busy && in_item.kind == KIND_DRAW &&
    in_item.max_value == '0, strobe_r && out_r.raw_word == '0 && state_r == S_IDLE,
    "zero-bound draw not answered at once")
  `MTG_ASSERT_NEXT(a_reseed_start, start && !busy && in_item.kind == KIND_RESEED,
    state_r == S_SEED0, "reseed beat did not start seeding")
  `MTG_ASSERT_NOW(a_seed_idx, state_r == S_SEED_MUL || state_r == S_SEED_ADD,
    idx_r != '0, "seeding index wrapped to entry zero")

endmodule

`default_nettype wire

FILE: rtl/mt19937_generator_top.sv
// ----------------------------------------------------------------------------
// MT19937 generator top level
// Mersenne Twister draws with a scaled value; seeding, twist and tempering.
// ----------------------------------------------------------------------------
//  port group   dir  beat marker          contents
//  in_          in   start && !busy       kind, max_value
//  out_         out  out_strobe           raw_word, scaled_value
//  cfg_         in   cfg_we               index 0..7, 32-bit data
//
//  Draw from a ready table: read, four temper steps, multiply, then scale.
//  Twist: after a load of word 0, a dual read and a write back per word.
//  Seeding: word 0 takes the seed; each later word passes the multiplier.
//  Zero-bound draw: result in the cycle after the beat, busy stays low.
//  Synchronous reset clears control; the table is filled by seeding.
//  Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_generator_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire mtg_pkg::in_item_t             in_item,
  output logic                               busy,
  output logic                               out_strobe,
  output mtg_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_we,
  input  wire logic [mtg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mtg_pkg::WORD_W-1:0]    cfg_data
);
  import mtg_pkg::*;

  cfg_t cfg;

  mtg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_r     (cfg)
  );

  mtg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
